// ===== sv/rmsd_pkg.sv =====
// Shared constants, types and helper functions for the RGB matrix scan driver.
`default_nettype none

package rmsd_pkg;

  // Panel geometry
  localparam int PANEL_COLUMNS = 64;
  localparam int SCAN_ROWS     = 20;
  localparam int MAX_ACROSS    = 4;
  localparam int MAX_DOWN      = 2;

  // Field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int XIN_W   = 9;
  localparam int YIN_W   = 7;
  localparam int LEVEL_W = 8;
  localparam int ROWA_W  = 5;
  localparam int TICKS_W = 16;
  localparam int WIDE_W  = 3;
  localparam int HIGH_W  = 2;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 16;

  localparam int DEFAULT_TICKS = 50;

  // Derived sizes
  localparam int STRIDE     = MAX_ACROSS * PANEL_COLUMNS;
  localparam int HALF_ROWS  = MAX_DOWN * SCAN_ROWS;
  localparam int HALF_DEPTH = HALF_ROWS * STRIDE;
  localparam int ADDR_W     = $clog2(HALF_DEPTH);
  localparam int X_W        = $clog2(STRIDE);
  localparam int COL_W      = $clog2(PANEL_COLUMNS);
  localparam int PROW_W     = $clog2(HALF_ROWS);
  localparam int ROW_W      = $clog2(SCAN_ROWS);
  localparam int SHIFT_W    = $clog2(MAX_ACROSS * MAX_DOWN * PANEL_COLUMNS + 1);
  localparam int K_W        = SHIFT_W - COL_W;
  localparam int EFFW_W     = $clog2(MAX_ACROSS + 1);
  localparam int EFFH_W     = $clog2(MAX_DOWN + 1);
  localparam int XP_W       = (MAX_ACROSS > 1) ? $clog2(MAX_ACROSS) : 1;
  localparam int PY_W       = (MAX_DOWN > 1) ? $clog2(MAX_DOWN) : 1;
  localparam int Q_W        = $clog2(2 * MAX_DOWN);
  localparam int CMP_W      = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Register indexes
  localparam logic [CFGI_W-1:0] REG_PANELS_WIDE   = 2'd0;
  localparam logic [CFGI_W-1:0] REG_PANELS_HIGH   = 2'd1;
  localparam logic [CFGI_W-1:0] REG_DISPLAY_TICKS = 2'd2;

  typedef enum logic [3:0] {
    PH_SHIFT   = 4'b0001,
    PH_LATCH   = 4'b0010,
    PH_DISPLAY = 4'b0100,
    PH_BLANK   = 4'b1000
  } phase_t;

  typedef logic [2:0] rgb_t;  // bit 0 red, bit 1 green, bit 2 blue

  typedef struct packed {
    logic              en;
    logic              bottom;
    logic [ADDR_W-1:0] addr;
    rgb_t              data;
  } wr_req_t;

  typedef struct packed {
    logic              strobe;
    logic              latch;
    logic              oen_n;
    logic [ROWA_W-1:0] row;
  } tick_info_t;

  typedef struct packed {
    logic [PY_W-1:0] py;
    logic [XP_W-1:0] xp;
  } split_t;

  typedef struct packed {
    logic              bottom;
    logic [PROW_W-1:0] prow;
  } yaddr_t;

  function automatic logic [EFFW_W-1:0] clamp_wide(input logic [WIDE_W-1:0] v);
    logic [EFFW_W-1:0] r;
    if (v == '0) r = EFFW_W'(1);
    else if (int'(v) > MAX_ACROSS) r = EFFW_W'(MAX_ACROSS);
    else r = EFFW_W'(v);
    return r;
  endfunction

  function automatic logic [EFFH_W-1:0] clamp_high(input logic [HIGH_W-1:0] v);
    logic [EFFH_W-1:0] r;
    if (v == '0) r = EFFH_W'(1);
    else if (int'(v) > MAX_DOWN) r = EFFH_W'(MAX_DOWN);
    else r = EFFH_W'(v);
    return r;
  endfunction

  // Split a panel-column index into stacked panel and panel across.
  function automatic split_t panel_split(input logic [K_W-1:0] k,
                                         input logic [EFFW_W-1:0] w);
    logic [K_W-1:0]  r;
    logic [PY_W-1:0] py;
    split_t          s;
    r  = k;
    py = '0;
    for (int i = 0; i < MAX_DOWN - 1; i++) begin
      if (r >= K_W'(w)) begin
        r  = r - K_W'(w);
        py = py + 1'b1;
      end
    end
    s.py = py;
    s.xp = XP_W'(r);
    return s;
  endfunction

  // Map a pixel row onto the top or bottom half store and its row there.
  function automatic yaddr_t y_split(input logic [YIN_W-1:0] y);
    logic [Q_W-1:0]   q;
    logic [YIN_W-1:0] r;
    yaddr_t           a;
    q = '0;
    for (int i = 1; i < 2 * MAX_DOWN; i++) begin
      if (y >= YIN_W'(i * SCAN_ROWS)) q = Q_W'(i);
    end
    r        = y - YIN_W'(q) * YIN_W'(SCAN_ROWS);
    a.bottom = q[0];
    a.prow   = PROW_W'(q >> 1) * PROW_W'(SCAN_ROWS) + PROW_W'(r);
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rmsd_frame_store.sv =====
// Frame store: top and bottom half memories with a clearing sweep.
`default_nettype none

module rmsd_frame_store (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear_req,
  output      logic                       busy,
  input  wire rmsd_pkg::wr_req_t          wr,
  input  wire logic [rmsd_pkg::ADDR_W-1:0] rd_addr,
  output      rmsd_pkg::rgb_t             rd_top,
  output      rmsd_pkg::rgb_t             rd_bot
);
  import rmsd_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } store_state_t;

  store_state_t      state;
  logic [ADDR_W-1:0] clr_addr;

  rgb_t mem_top [HALF_DEPTH];
  rgb_t mem_bot [HALF_DEPTH];

  assign busy = (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(HALF_DEPTH - 1)) begin
            state <= ST_RUN;
          end
          clr_addr <= clr_addr + 1'b1;
        end
        ST_RUN: begin
          if (clear_req) begin
            state <= ST_CLEAR;
          end
          clr_addr <= '0;
        end
        default: begin
          state    <= ST_CLEAR;
          clr_addr <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem_top[clr_addr] <= '0;
      mem_bot[clr_addr] <= '0;
    end else if (wr.en) begin
      if (wr.bottom) mem_bot[wr.addr] <= wr.data;
      else mem_top[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_top <= mem_top[rd_addr];
    rd_bot <= mem_bot[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/rmsd_scan_ctrl.sv =====
// Scan sequencer: shift, latch, display and blank phases per row.
`default_nettype none

module rmsd_scan_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [rmsd_pkg::EFFW_W-1:0]  eff_w,
  input  wire logic [rmsd_pkg::EFFH_W-1:0]  eff_h,
  input  wire logic [rmsd_pkg::TICKS_W-1:0] display_ticks,
  output      logic [rmsd_pkg::ADDR_W-1:0]  rd_addr,
  output      rmsd_pkg::tick_info_t        info
);
  import rmsd_pkg::*;

  phase_t             phase, phase_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [SHIFT_W-1:0] sp, sp_next;
  logic [TICKS_W-1:0] dc, dc_next;

  logic [SHIFT_W-1:0] total;
  logic [SHIFT_W-1:0] sp_inc;
  logic               overrun;
  split_t             split;
  logic [X_W-1:0]     col;
  logic [PROW_W-1:0]  prow;
  logic [TICKS_W-1:0] limit;
  logic [TICKS_W:0]   dc_inc;

  assign total   = SHIFT_W'(eff_w) * SHIFT_W'(eff_h) * SHIFT_W'(PANEL_COLUMNS);
  assign overrun = (phase == PH_SHIFT) && (sp >= total);
  assign sp_inc  = sp + 1'b1;
  assign split   = panel_split(sp[SHIFT_W-1:COL_W], eff_w);
  assign col     = X_W'(split.xp) * X_W'(PANEL_COLUMNS) + X_W'(sp[COL_W-1:0]);
  assign prow    = PROW_W'(split.py) * PROW_W'(SCAN_ROWS) + PROW_W'(row);
  assign rd_addr = ADDR_W'(prow) * ADDR_W'(STRIDE) + ADDR_W'(col);
  assign limit   = (display_ticks == '0) ? TICKS_W'(1) : display_ticks;
  assign dc_inc  = {1'b0, dc} + 1'b1;

  always_comb begin
    phase_next  = phase;
    row_next    = row;
    sp_next     = sp;
    dc_next     = dc;
    info.strobe = 1'b0;
    info.latch  = 1'b0;
    info.oen_n  = 1'b1;
    info.row    = ROWA_W'(row);
    if (overrun) begin
      // grid shrank under the shift: treat this tick as the latch tick
      sp_next    = '0;
      info.latch = 1'b1;
      dc_next    = '0;
      phase_next = PH_DISPLAY;
    end else begin
      unique case (phase)
        PH_SHIFT: begin
          info.strobe = 1'b1;
          if (sp_inc >= total) begin
            sp_next    = '0;
            phase_next = PH_LATCH;
          end else begin
            sp_next = sp_inc;
          end
        end
        PH_LATCH: begin
          info.latch = 1'b1;
          dc_next    = '0;
          phase_next = PH_DISPLAY;
        end
        PH_DISPLAY: begin
          info.oen_n = 1'b0;
          if (dc_inc >= {1'b0, limit}) begin
            dc_next    = '0;
            phase_next = PH_BLANK;
          end else begin
            dc_next = dc_inc[TICKS_W-1:0];
          end
        end
        PH_BLANK: begin
          row_next   = (int'(row) + 1 >= SCAN_ROWS) ? '0 : row + 1'b1;
          sp_next    = '0;
          phase_next = PH_SHIFT;
        end
        default: begin
          phase_next = PH_SHIFT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SHIFT;
      row   <= '0;
      sp    <= '0;
      dc    <= '0;
    end else if (step) begin
      phase <= phase_next;
      row   <= row_next;
      sp    <= sp_next;
      dc    <= dc_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rgb_matrix_scan_driver.sv =====
// Top level of the RGB LED matrix scan driver.
// Usage:
//   Requests arrive on in_valid/in_ready with a command and pixel fields.
//   A write request stores one pixel (each colour kept as a nonzero flag);
//   writes outside the configured grid are dropped. A clear request zeroes
//   the frame store by sweeping it, during which in_ready is low. A tick
//   request steps the panel scan and yields one result on out_valid/out_ready
//   carrying the colour data, strobe, latch, output enable and row address
//   for that tick.
//   A tick result passes through the frame store's registered read port and
//   then the result register. A new tick is not taken while the last one's
//   read is in flight; writes are taken one per cycle while in_ready is high,
//   and a clear holds in_ready low for its sweep.
//   The single result register is the only buffer: while it holds a result
//   that is not taken, no request is accepted.
//   Reset: the scan restarts at row 0 in the shift phase, the registers return
//   to one panel wide, one high and 50 display ticks, and the store is swept
//   clear before the first request is taken.
//   Configuration writes on cfg_write are taken on any cycle.
`default_nettype none

module rgb_matrix_scan_driver (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [rmsd_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [rmsd_pkg::CFGD_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [rmsd_pkg::CMD_W-1:0]   command,
  input  wire logic [rmsd_pkg::XIN_W-1:0]   x,
  input  wire logic [rmsd_pkg::YIN_W-1:0]   y,
  input  wire logic [rmsd_pkg::LEVEL_W-1:0] red,
  input  wire logic [rmsd_pkg::LEVEL_W-1:0] green,
  input  wire logic [rmsd_pkg::LEVEL_W-1:0] blue,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic                         red_top,
  output      logic                         green_top,
  output      logic                         blue_top,
  output      logic                         red_bottom,
  output      logic                         green_bottom,
  output      logic                         blue_bottom,
  output      logic                         shift_strobe,
  output      logic                         latch_pulse,
  output      logic                         output_enable_n,
  output      logic [rmsd_pkg::ROWA_W-1:0]  row_address
);
  import rmsd_pkg::*;

  logic [WIDE_W-1:0]  panels_wide;
  logic [HIGH_W-1:0]  panels_high;
  logic [TICKS_W-1:0] display_ticks;
  logic [EFFW_W-1:0]  eff_w;
  logic [EFFH_W-1:0]  eff_h;

  logic       accept;
  logic       tick_accept;
  logic       clear_accept;
  logic       in_grid;
  logic       store_busy;
  logic       rd_pend;
  yaddr_t     ya;
  wr_req_t    wr;
  tick_info_t tick_info;
  tick_info_t pend_info;
  rgb_t       rd_top;
  rgb_t       rd_bot;
  logic [ADDR_W-1:0] rd_addr;

  assign eff_w = clamp_wide(panels_wide);
  assign eff_h = clamp_high(panels_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      panels_wide   <= WIDE_W'(1);
      panels_high   <= HIGH_W'(1);
      display_ticks <= TICKS_W'(DEFAULT_TICKS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PANELS_WIDE:   panels_wide   <= cfg_data[WIDE_W-1:0];
        REG_PANELS_HIGH:   panels_high   <= cfg_data[HIGH_W-1:0];
        REG_DISPLAY_TICKS: display_ticks <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // hold requests while sweeping, while a read is in flight or the result waits
  assign in_ready     = !store_busy && !rd_pend && (!out_valid || out_ready);
  assign accept       = in_valid && in_ready;
  assign tick_accept  = accept && (command == CMD_TICK);
  assign clear_accept = accept && (command == CMD_CLEAR);

  assign in_grid = (CMP_W'(x) < CMP_W'(eff_w) * CMP_W'(PANEL_COLUMNS)) &&
                   (CMP_W'(y) < CMP_W'(eff_h) * CMP_W'(2 * SCAN_ROWS));
  assign ya      = y_split(y);

  always_comb begin
    wr.en     = accept && (command == CMD_WRITE) && in_grid;
    wr.bottom = ya.bottom;
    wr.addr   = ADDR_W'(ya.prow) * ADDR_W'(STRIDE) + ADDR_W'(x[X_W-1:0]);
    wr.data   = {blue != '0, green != '0, red != '0};
  end

  rmsd_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .clear_req (clear_accept),
    .busy      (store_busy),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_top    (rd_top),
    .rd_bot    (rd_bot)
  );

  rmsd_scan_ctrl u_scan (
    .clk           (clk),
    .rst           (rst),
    .step          (tick_accept),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .display_ticks (display_ticks),
    .rd_addr       (rd_addr),
    .info          (tick_info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= tick_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) pend_info <= tick_info;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // colour data only on shift ticks
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      red_top         <= pend_info.strobe & rd_top[0];
      green_top       <= pend_info.strobe & rd_top[1];
      blue_top        <= pend_info.strobe & rd_top[2];
      red_bottom      <= pend_info.strobe & rd_bot[0];
      green_bottom    <= pend_info.strobe & rd_bot[1];
      blue_bottom     <= pend_info.strobe & rd_bot[2];
      shift_strobe    <= pend_info.strobe;
      latch_pulse     <= pend_info.latch;
      output_enable_n <= pend_info.oen_n;
      row_address     <= pend_info.row;
    end
  end

`ifndef SYNTH
  a_no_request_while_sweeping: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !in_ready)
    else $error("request accepted during store sweep");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("tick read completed with result register occupied");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(rd_pend))
    else $error("result appeared without a store read");

  a_exclusive_controls: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({shift_strobe, latch_pulse, !output_enable_n}) <= 1))
    else $error("strobe, latch and output enable overlap");
`endif

endmodule

`default_nettype wire
